// ===== sv/bst_pkg.sv =====
// ----------------------------------------------------------------------------
// bst_pkg: shared types for the bounded set table
// Action and status codes, controller states and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bst_pkg;

  localparam int DEFAULT_CAPACITY = 128;
  localparam int ELEM_W           = 8;
  localparam int COUNT_OUT_W      = 8;

  typedef enum logic [1:0] {
    ACT_FIND   = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_DELETE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_ABSENT    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_DEL_RD,
    S_DEL_WR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic exec;
    logic del_rd;
    logic del_wr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic del_needed;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

// ===== sv/bst_ram.sv =====
// ----------------------------------------------------------------------------
// bst_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/bst_ctrl.sv =====
// ----------------------------------------------------------------------------
// bst_ctrl: sequencer for the bounded set table
// Walks each transaction through scan, execute, delete move-down and
// result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_ctrl
  import bst_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.hit || stat.scan_end) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = stat.del_needed ? S_DEL_RD : S_FINISH;
      end
      S_DEL_RD: state_next = S_DEL_WR;
      S_DEL_WR: state_next = S_FINISH;
      S_FINISH: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      S_SCAN:   cmd.scan   = 1'b1;
      S_EXEC:   cmd.exec   = 1'b1;
      S_DEL_RD: cmd.del_rd = 1'b1;
      S_DEL_WR: cmd.del_wr = 1'b1;
      S_FINISH: cmd.load_out = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/bst_dp.sv =====
// ----------------------------------------------------------------------------
// bst_dp: datapath for the bounded set table
// Entry store, element count, scan pointer with read pipeline, and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_dp
  import bst_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [1:0]             action,
  input  wire logic [ELEM_W-1:0]      element,
  input  wire cmd_t                   cmd,
  output stat_t                       stat,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        present,
  output logic [1:0]                  status,
  output logic [COUNT_OUT_W-1:0]      member_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [1:0]        act;
  logic [ELEM_W-1:0] elem;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic              pend;
  logic [AW-1:0]     pend_idx;
  logic              found;
  logic [AW-1:0]     slot;
  logic              res_present;
  status_t           res_status;

  logic                   full;
  logic                   issue;
  logic                   add_ok;
  logic [CW-1:0]          last;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [ELEM_W-1:0]      wdata;
  logic [AW-1:0]          raddr;
  logic [ELEM_W-1:0]      rdata;
  logic [CW+COUNT_OUT_W-1:0] count_ext;

  assign full   = (count >= CW'(CAPACITY));
  assign issue  = (idx < count);
  assign add_ok = (act == ACT_ADD) && !found && !full;
  assign last   = count - 1'b1;

  assign stat.hit        = pend && (rdata == elem);
  assign stat.scan_end   = !pend && !issue;
  assign stat.del_needed = (act == ACT_DELETE) && found;
  assign stat.out_busy   = out_valid && !out_ready;

  assign raddr = cmd.del_rd ? last[AW-1:0] : idx[AW-1:0];
  assign we    = (cmd.exec && add_ok) || cmd.del_wr;
  assign waddr = cmd.del_wr ? slot : count[AW-1:0];
  assign wdata = cmd.del_wr ? rdata : elem;

  bst_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act   <= action;
      elem  <= element;
      idx   <= '0;
      pend  <= 1'b0;
      found <= 1'b0;
    end else if (cmd.scan) begin
      pend     <= issue;
      pend_idx <= idx[AW-1:0];
      if (issue) idx <= idx + 1'b1;
      if (stat.hit) begin
        found <= 1'b1;
        slot  <= pend_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec && add_ok) begin
      count <= count + 1'b1;
    end else if (cmd.del_wr) begin
      count <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_present <= found;
      if (act == ACT_ADD) begin
        if (found)     res_status <= ST_DUPLICATE;
        else if (full) res_status <= ST_FULL;
        else           res_status <= ST_DONE;
      end else begin
        res_status <= found ? ST_DONE : ST_ABSENT;
      end
    end
  end

  assign count_ext = {{COUNT_OUT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      present      <= res_present;
      status       <= res_status;
      member_count <= count_ext[COUNT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bounded_set_table.sv =====
// ----------------------------------------------------------------------------
// bounded_set_table: unordered set of distinct bytes with find, add, delete
// Linear scan of the entry RAM per transaction, count kept alongside.
// ----------------------------------------------------------------------------
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------
//   in      | in_valid / in_ready  | action[1:0], element[7:0]
//   out     | out_valid / out_ready| present, status[1:0], member_count[7:0]
//
// A transaction scans the entry RAM through its read port, one entry per cycle,
// until a hit or the end of the set; a delete that hits then moves the last
// entry into the freed slot.
// Synchronous reset empties the set at once; entries need no clearing.
// A finished result waits in the output register; a new transaction may
// start meanwhile and holds at its end until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_set_table
  import bst_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             action,
  input  wire logic [ELEM_W-1:0]      element,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        present,
  output logic [1:0]                  status,
  output logic [COUNT_OUT_W-1:0]      member_count
);

  cmd_t  cmd;
  stat_t stat;

  bst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bst_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .action       (action),
    .element      (element),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .present      (present),
    .status       (status),
    .member_count (member_count)
  );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bounded set table
// Sends find, add and delete transactions, and the spare action code, in
// bursts with random gaps. The output side stalls on a rotating pattern.
// A shadow copy of the set predicts every result, which is checked field by
// field in order. The directed part covers an empty set, duplicates, a
// delete that moves the last entry into the freed slot, and the spare code.
// Random segments then fill the set past its capacity, drain it, mix
// operations at random and churn a narrow band of values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import bst_pkg::*;

  localparam int SET_CAP      = DEFAULT_CAPACITY;
  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int MAX_REPORTS  = 10;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]        act;
    logic [ELEM_W-1:0] elem;
  } set_op_t;

  typedef struct packed {
    logic                   present;
    status_t                status;
    logic [COUNT_OUT_W-1:0] members;
  } set_result_t;

  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIX, SEG_NARROW} segment_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             action = ACT_FIND;
  logic [ELEM_W-1:0]      element = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   present;
  logic [1:0]             status;
  logic [COUNT_OUT_W-1:0] member_count;

  set_op_t           pending_ops[$];
  set_result_t       expected_results[$];
  logic [ELEM_W-1:0] added_history[$];
  logic [ELEM_W-1:0] held_elems[SET_CAP];
  int                held_count = 0;

  int action_seen[4] = '{0, 0, 0, 0};
  int full_refusals = 0;
  int dup_refusals = 0;
  int peak_count = 0;

  int          burst_left = 1;
  int          gap_left = 0;
  set_op_t     launch_op;
  set_result_t want;
  logic [15:0] stall_pattern = 16'hFFFF;
  int          pattern_age = 0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          cycle_count = 0;

  bounded_set_table dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .element      (element),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .present      (present),
    .status       (status),
    .member_count (member_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void queue_set_op(input logic [1:0] act, input logic [ELEM_W-1:0] elem);
    set_op_t op;
    op.act  = act;
    op.elem = elem;
    pending_ops.push_back(op);
    if (act == ACT_ADD) begin
      added_history.push_back(elem);
    end
  endfunction

  function automatic logic [ELEM_W-1:0] recent_element();
    int depth;
    int span;
    depth = added_history.size();
    if (depth == 0) begin
      return ELEM_W'($urandom_range(0, 255));
    end
    span = (depth > 256) ? 256 : depth;
    return added_history[depth - 1 - $urandom_range(0, span - 1)];
  endfunction

  function automatic void apply_set_op(input logic [1:0] act, input logic [ELEM_W-1:0] elem);
    int          slot;
    int          k;
    set_result_t res;
    slot = -1;
    for (k = 0; k < held_count; k++) begin
      if (slot < 0 && held_elems[k] == elem) begin
        slot = k;
      end
    end
    res.present = (slot >= 0);
    if (act == ACT_ADD) begin
      if (slot >= 0) begin
        res.status = ST_DUPLICATE;
        dup_refusals++;
      end else if (held_count >= SET_CAP) begin
        res.status = ST_FULL;
        full_refusals++;
      end else begin
        held_elems[held_count] = elem;
        held_count++;
        res.status = ST_DONE;
      end
    end else if (act == ACT_DELETE) begin
      if (slot >= 0) begin
        held_count--;
        held_elems[slot] = held_elems[held_count];
        res.status = ST_DONE;
      end else begin
        res.status = ST_ABSENT;
      end
    end else begin
      res.status = (slot >= 0) ? ST_DONE : ST_ABSENT;
    end
    res.members = held_count[COUNT_OUT_W-1:0];
    if (held_count > peak_count) begin
      peak_count = held_count;
    end
    action_seen[act]++;
    expected_results.push_back(res);
  endfunction

  // Sender: bursts of transactions separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_set_op(action, element);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          launch_op = pending_ops.pop_front();
          in_valid <= 1'b1;
          action   <= launch_op.act;
          element  <= launch_op.elem;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result, stall on a rotating pattern.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] result %0d arrived with nothing outstanding", $realtime, results_seen);
          end
        end else begin
          want = expected_results.pop_front();
          if (present !== want.present || status !== want.status ||
              member_count !== want.members) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("[%0t] result %0d: want present=%0b status=%0d members=%0d",
                       $realtime, results_seen, want.present, want.status, want.members);
              $display("            got  present=%0b status=%0d members=%0d",
                       present, status, member_count);
            end
          end
        end
      end
      pattern_age++;
      if (pattern_age >= 48) begin
        pattern_age = 0;
        case ($urandom_range(0, 2))
          0: begin
            stall_pattern = 16'hFFFF;
          end
          1: begin
            stall_pattern = 16'($urandom);
          end
          default: begin
            stall_pattern = 16'($urandom | $urandom);
          end
        endcase
      end
      out_ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int       directed_count;
    int       seg_len;
    int       stride;
    int       pick;
    int       i;
    logic [ELEM_W-1:0] base;
    segment_t seg;

    queue_set_op(ACT_FIND, 8'h00);
    queue_set_op(ACT_DELETE, 8'hFF);
    queue_set_op(ACT_SPARE, 8'h00);
    queue_set_op(ACT_ADD, 8'h00);
    queue_set_op(ACT_ADD, 8'h00);
    queue_set_op(ACT_ADD, 8'hFF);
    queue_set_op(ACT_ADD, 8'h80);
    queue_set_op(ACT_FIND, 8'hFF);
    queue_set_op(ACT_SPARE, 8'h80);
    queue_set_op(ACT_SPARE, 8'h07);
    queue_set_op(ACT_DELETE, 8'h00);
    queue_set_op(ACT_FIND, 8'h80);
    queue_set_op(ACT_DELETE, 8'h00);
    queue_set_op(ACT_DELETE, 8'h80);
    queue_set_op(ACT_DELETE, 8'hFF);
    queue_set_op(ACT_FIND, 8'hFF);
    queue_set_op(ACT_ADD, 8'h55);
    queue_set_op(ACT_ADD, 8'hAA);
    queue_set_op(ACT_DELETE, 8'hAA);
    queue_set_op(ACT_DELETE, 8'h55);
    directed_count = pending_ops.size();

    // Open with a fill so the full-set cases are always reached.
    seg = SEG_FILL;
    while (pending_ops.size() < directed_count + RANDOM_ITEMS) begin
      case (seg)
        SEG_FILL: begin
          base    = ELEM_W'($urandom_range(0, 255));
          stride  = 2 * $urandom_range(0, 127) + 1;
          seg_len = SET_CAP + $urandom_range(12, 40);
          for (i = 0; i < seg_len; i++) begin
            queue_set_op(ACT_ADD, ELEM_W'(base + i * stride));
          end
          seg_len = $urandom_range(15, 30);
          for (i = 0; i < seg_len; i++) begin
            pick = $urandom_range(0, 2);
            if (pick == 0) begin
              queue_set_op(ACT_ADD, recent_element());
            end else if (pick == 1) begin
              queue_set_op(ACT_ADD, ELEM_W'($urandom_range(0, 255)));
            end else begin
              queue_set_op(ACT_FIND, recent_element());
            end
          end
        end
        SEG_DRAIN: begin
          seg_len = $urandom_range(60, 200);
          for (i = 0; i < seg_len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 75 && added_history.size() > 0) begin
              queue_set_op(ACT_DELETE, added_history.pop_back());
            end else if (pick < 88) begin
              queue_set_op(ACT_DELETE, ELEM_W'($urandom_range(0, 255)));
            end else if (pick < 96) begin
              queue_set_op(ACT_FIND, recent_element());
            end else begin
              queue_set_op(ACT_ADD, ELEM_W'($urandom_range(0, 255)));
            end
          end
        end
        SEG_MIX: begin
          seg_len = $urandom_range(40, 150);
          for (i = 0; i < seg_len; i++) begin
            if ($urandom_range(0, 1) == 0) begin
              queue_set_op(2'($urandom_range(0, 3)), recent_element());
            end else begin
              queue_set_op(2'($urandom_range(0, 3)), ELEM_W'($urandom_range(0, 255)));
            end
          end
        end
        default: begin
          base    = ELEM_W'($urandom_range(0, 255));
          seg_len = $urandom_range(40, 120);
          for (i = 0; i < seg_len; i++) begin
            queue_set_op(2'($urandom_range(0, 3)), ELEM_W'(base + $urandom_range(0, 7)));
          end
        end
      endcase
      seg = segment_t'($urandom_range(0, 3));
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (SET_CAP + 16) @(posedge clk);

    $display("Sent %0d transactions: %0d finds, %0d adds, %0d deletes, %0d spare-code finds",
             results_seen, action_seen[ACT_FIND], action_seen[ACT_ADD],
             action_seen[ACT_DELETE], action_seen[ACT_SPARE]);
    $display("Peak occupancy %0d of %0d; %0d adds refused full, %0d as duplicates; %0d bad",
             peak_count, SET_CAP, full_refusals, dup_refusals, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
